>>> rtl/chunked_read_deframer_crc32_assert.svh
// Assertion macros for the chunked read deframer; need clk and rst in scope.
`ifndef CHUNKED_READ_DEFRAMER_CRC32_ASSERT_SVH
`define CHUNKED_READ_DEFRAMER_CRC32_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CRDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crdc assertion failed in %m");
`define CRDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crdc assertion failed in %m");
`else
`define CRDC_ASSERT_IMP(lbl, ante, cons)
`define CRDC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/crdc_pkg.sv
// Shared types, codes and helper functions of the chunked read deframer.
package crdc_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_FAIL  = 2'd2;

  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PROTO     = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_TRANSPORT = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam logic [31:0] MAGIC_REQ   = 32'h4348_5233;
  localparam logic [31:0] MAGIC_ACK   = 32'h4348_4F4B;
  localparam logic [31:0] MAGIC_CHUNK = 32'h4348_4E4B;
  localparam logic [31:0] MAGIC_DONE  = 32'h4348_444E;

  localparam logic [7:0]  REQ_VERSION = 8'd1;
  localparam logic [7:0]  OP_READ     = 8'd1;
  localparam int          REQ_LEN     = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [31:0] MAX_CHUNK_DEF = 32'd65536;
  localparam int          QUEUE_DEPTH_DEF = 4;

  // One queued job for the back end. For a request, pos/len carry offset/length.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] pos;
    logic [31:0] len;
    logic [2:0]  status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Reflected CRC-32, one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Byte idx of the outgoing read request frame.
  function automatic logic [7:0] req_byte(input logic [3:0] idx, input logic [31:0] off,
                                          input logic [31:0] len);
    logic [7:0] b;
    case (idx)
      4'd0:    b = MAGIC_REQ[31:24];
      4'd1:    b = MAGIC_REQ[23:16];
      4'd2:    b = MAGIC_REQ[15:8];
      4'd3:    b = MAGIC_REQ[7:0];
      4'd4:    b = REQ_VERSION;
      4'd5:    b = OP_READ;
      4'd8:    b = off[31:24];
      4'd9:    b = off[23:16];
      4'd10:   b = off[15:8];
      4'd11:   b = off[7:0];
      4'd12:   b = len[31:24];
      4'd13:   b = len[23:16];
      4'd14:   b = len[15:8];
      4'd15:   b = len[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/crdc_if.sv
// Valid/ready channel interfaces for input words and result words.
interface crdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] read_offset;
  logic [31:0] read_length;
  logic [7:0]  rx_byte;

  modport source (output valid, func, read_offset, read_length, rx_byte, input ready);
  modport sink   (input valid, func, read_offset, read_length, rx_byte, output ready);
endinterface

interface crdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] payload_position;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, data_byte, payload_position, status, last,
                  input ready);
  modport sink   (input valid, kind, data_byte, payload_position, status, last,
                  output ready);
endinterface

>>> rtl/chunked_read_deframer_crc32.sv
// Top level of the chunked read deframer with payload CRC-32 check.
// An accepted input word reaches its first result word by the queue write, then the
//   output register load when the output side is free. Throughput: one input word
//   per cycle; a start expands into 16 request bytes at one per cycle while the output
//   accepts them, other words give at most one; input stalls while the queue is full.
// Reset (rst, synchronous): phase idle, queue empty, output invalid.
`include "chunked_read_deframer_crc32_assert.svh"

module chunked_read_deframer_crc32 #(
  parameter logic [31:0] MAX_CHUNK   = crdc_pkg::MAX_CHUNK_DEF,
  parameter int          QUEUE_DEPTH = crdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  crdc_in_if.sink    item,
  crdc_out_if.source result
);
  crdc_pkg::cmd_t    q_wdata;
  crdc_pkg::cmd_t    q_head;
  crdc_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;

  // Front end: header parsing, checks, CRC, all state of the read.
  crdc_front #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd      (q_wdata),
    .cmd_push (q_push),
    .qs       (q_stat)
  );

  // Decouples parsing from output back-pressure.
  crdc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  // Back end: request frame serializer and output register.
  crdc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .qs     (q_stat),
    .pop    (q_pop),
    .result (result)
  );

  // Queue must never be written when full or read when empty.
  `CRDC_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full)
  `CRDC_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty)
  // A push with no pop leaves something queued.
  `CRDC_ASSERT_NXT(a_push_holds, q_push && !q_pop, !q_stat.empty)
  // Status and payload words each close their run.
  `CRDC_ASSERT_IMP(a_single_last,
    result.valid && (result.kind == crdc_pkg::KIND_STAT ||
                     result.kind == crdc_pkg::KIND_PAY), result.last)
endmodule

>>> rtl/crdc_fifo.sv
// Small command queue between the parsing front end and the output back end.
module crdc_fifo #(
  parameter int DEPTH = crdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crdc_pkg::cmd_t   wdata,
  input  logic             pop,
  output crdc_pkg::cmd_t   rdata,
  output crdc_pkg::q_stat_t stat
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  crdc_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

>>> rtl/crdc_front.sv
// Front end: takes input words, parses headers, checks, keeps CRC, queues jobs.
module crdc_front #(
  parameter logic [31:0] MAX_CHUNK = crdc_pkg::MAX_CHUNK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  crdc_in_if.sink           item,
  output crdc_pkg::cmd_t    cmd,
  output logic              cmd_push,
  input  crdc_pkg::q_stat_t qs
);
  localparam int CW = $clog2(64'(MAX_CHUNK) + 64'd1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACK,
    PH_CHDR,
    PH_DATA,
    PH_DONE
  } phase_t;

  phase_t        phase, phase_next;
  logic [3:0]    header_count, header_count_next;
  logic [31:0]   header_word, header_word_next;
  logic [31:0]   requested_length, requested_length_next;
  logic [31:0]   bytes_remaining, bytes_remaining_next;
  logic [31:0]   next_sequence, next_sequence_next;
  logic [CW-1:0] chunk_limit, chunk_limit_next;
  logic [CW-1:0] chunk_left, chunk_left_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [31:0]   write_position, write_position_next;

  logic        acc;
  logic [32:0] end_sum;
  logic [31:0] word;
  logic [3:0]  cnt_inc;
  logic [1:0]  idx;
  logic        fin;
  logic [2:0]  fin_st;

  assign item.ready = !qs.full;
  assign acc        = item.valid && item.ready;
  assign end_sum    = {1'b0, item.read_offset} + {1'b0, item.read_length};
  assign word       = {header_word[23:0], item.rx_byte};
  assign cnt_inc    = header_count + 4'd1;
  assign idx        = cnt_inc[3:2] - 2'd1;

  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    header_word_next      = header_word;
    requested_length_next = requested_length;
    bytes_remaining_next  = bytes_remaining;
    next_sequence_next    = next_sequence;
    chunk_limit_next      = chunk_limit;
    chunk_left_next       = chunk_left;
    running_crc_next      = running_crc;
    write_position_next   = write_position;
    cmd_push              = 1'b0;
    cmd                   = '0;
    fin                   = 1'b0;
    fin_st                = crdc_pkg::ST_OK;

    if (acc) begin
      case (item.func)
        crdc_pkg::FUNC_START: begin
          if (end_sum[32]) begin
            fin    = 1'b1;
            fin_st = crdc_pkg::ST_RANGE;
          end else begin
            cmd_push              = 1'b1;
            cmd.kind              = crdc_pkg::KIND_REQ;
            cmd.pos               = item.read_offset;
            cmd.len               = item.read_length;
            requested_length_next = item.read_length;
            bytes_remaining_next  = item.read_length;
            next_sequence_next    = '0;
            chunk_limit_next      = '0;
            chunk_left_next       = '0;
            running_crc_next      = crdc_pkg::CRC_INIT;
            write_position_next   = '0;
            phase_next            = PH_ACK;
            header_count_next     = '0;
            header_word_next      = '0;
          end
        end
        crdc_pkg::FUNC_BYTE: begin
          if (phase == PH_DATA) begin
            cmd_push             = 1'b1;
            cmd.kind             = crdc_pkg::KIND_PAY;
            cmd.data             = item.rx_byte;
            cmd.pos              = write_position;
            running_crc_next     = crdc_pkg::crc8(running_crc, item.rx_byte);
            write_position_next  = write_position + 32'd1;
            bytes_remaining_next = bytes_remaining - 32'd1;
            chunk_left_next      = chunk_left - CW'(1);
            if (chunk_left == CW'(1)) begin
              next_sequence_next = next_sequence + 32'd1;
              phase_next         = (bytes_remaining == 32'd1) ? PH_DONE : PH_CHDR;
              header_count_next  = '0;
              header_word_next   = '0;
            end
          end else if (phase != PH_IDLE) begin
            header_word_next  = word;
            header_count_next = cnt_inc;
            if (cnt_inc[1:0] == 2'd0) begin
              header_word_next = '0;
              case (phase)
                PH_ACK: begin
                  if (idx == 2'd0) begin
                    fin = (word != crdc_pkg::MAGIC_ACK);
                  end else if (idx == 2'd1) begin
                    fin = (word != requested_length);
                  end else if (word == '0 || word > MAX_CHUNK) begin
                    fin = 1'b1;
                  end else begin
                    chunk_limit_next  = word[CW-1:0];
                    phase_next        = (requested_length == '0) ? PH_DONE : PH_CHDR;
                    header_count_next = '0;
                  end
                  fin_st = crdc_pkg::ST_PROTO;
                end
                PH_CHDR: begin
                  if (idx == 2'd0) begin
                    fin = (word != crdc_pkg::MAGIC_CHUNK);
                  end else if (idx == 2'd1) begin
                    fin = (word != next_sequence);
                  end else if (word == '0 || word > 32'(chunk_limit) ||
                               word > bytes_remaining) begin
                    fin = 1'b1;
                  end else begin
                    chunk_left_next   = word[CW-1:0];
                    phase_next        = PH_DATA;
                    header_count_next = '0;
                  end
                  fin_st = crdc_pkg::ST_PROTO;
                end
                default: begin
                  // done frame: magic, then CRC of all payload bytes
                  if (idx == 2'd0) begin
                    fin    = (word != crdc_pkg::MAGIC_DONE);
                    fin_st = crdc_pkg::ST_PROTO;
                  end else begin
                    fin    = 1'b1;
                    fin_st = (word == ~running_crc) ? crdc_pkg::ST_OK : crdc_pkg::ST_CRC;
                  end
                end
              endcase
            end
          end
        end
        crdc_pkg::FUNC_FAIL: begin
          fin    = (phase != PH_IDLE);
          fin_st = crdc_pkg::ST_TRANSPORT;
        end
        default: begin
        end
      endcase

      if (fin) begin
        cmd_push          = 1'b1;
        cmd               = '0;
        cmd.kind          = crdc_pkg::KIND_STAT;
        cmd.status        = fin_st;
        phase_next        = PH_IDLE;
        header_count_next = '0;
        header_word_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      header_count     <= '0;
      header_word      <= '0;
      requested_length <= '0;
      bytes_remaining  <= '0;
      next_sequence    <= '0;
      chunk_limit      <= '0;
      chunk_left       <= '0;
      running_crc      <= crdc_pkg::CRC_INIT;
      write_position   <= '0;
    end else begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      header_word      <= header_word_next;
      requested_length <= requested_length_next;
      bytes_remaining  <= bytes_remaining_next;
      next_sequence    <= next_sequence_next;
      chunk_limit      <= chunk_limit_next;
      chunk_left       <= chunk_left_next;
      running_crc      <= running_crc_next;
      write_position   <= write_position_next;
    end
  end
endmodule

>>> rtl/crdc_back.sv
// Back end: expands queued jobs into result words through an output register.
module crdc_back (
  input  logic              clk,
  input  logic              rst,
  input  crdc_pkg::cmd_t    head,
  input  crdc_pkg::q_stat_t qs,
  output logic              pop,
  crdc_out_if.source        result
);
  localparam int BW = $clog2(crdc_pkg::REQ_LEN);

  logic [BW-1:0] beat;
  logic          load;
  logic          take;
  logic          is_req;
  logic          req_end;

  assign load    = !result.valid || result.ready;
  assign take    = load && !qs.empty;
  assign is_req  = (head.kind == crdc_pkg::KIND_REQ);
  assign req_end = (beat == BW'(crdc_pkg::REQ_LEN - 1));
  assign pop     = take && (!is_req || req_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      beat         <= '0;
    end else if (load) begin
      result.valid <= !qs.empty;
      if (take && is_req) begin
        beat <= req_end ? '0 : beat + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.kind <= head.kind;
      case (head.kind)
        crdc_pkg::KIND_REQ: begin
          result.data_byte        <= crdc_pkg::req_byte(beat, head.pos, head.len);
          result.payload_position <= '0;
          result.status           <= crdc_pkg::ST_OK;
          result.last             <= req_end;
        end
        crdc_pkg::KIND_PAY: begin
          result.data_byte        <= head.data;
          result.payload_position <= head.pos;
          result.status           <= crdc_pkg::ST_OK;
          result.last             <= 1'b1;
        end
        default: begin
          result.data_byte        <= '0;
          result.payload_position <= '0;
          result.status           <= head.status;
          result.last             <= 1'b1;
        end
      endcase
    end
  end
endmodule
